FILE: rtl/sle_pkg.sv
// shared types and codes for the sequential list engine
`default_nettype none
package sle_pkg;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_FIND   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [7:0]         position;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] removed_value;
    logic [7:0]         found_position;
    logic [7:0]         count;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/sle_cell.sv
// one list entry: holds an element and moves it to or from its neighbours
`default_nettype none
module sle_cell #(
  parameter int IDX = 0,
  parameter int IW  = 7
) (
  input  wire                   clk,
  input  wire sle_pkg::cell_op_t op,
  input  wire logic [IW-1:0]    index,
  input  wire logic [31:0]      value,
  input  wire logic [31:0]      left,
  input  wire logic [31:0]      right,
  output logic [31:0]           data
);
  import sle_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [31:0] data_next;

  always_comb begin
    data_next = data;
    case (op)
      CELL_APPEND: begin
        if (index == MY_IDX) data_next = value;
      end
      CELL_INSERT: begin
        // entries above the insert point move up by one
        if (MY_IDX > index) begin
          data_next = left;
        end else if (MY_IDX == index) begin
          data_next = value;
        end
      end
      CELL_ROTATE: data_next = right;
      default:     data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

FILE: rtl/sle_ctrl.sv
// request decode, rotation sequencer, element count and result register
`default_nettype none
module sle_ctrl #(
  parameter int CAPACITY = 128,
  parameter int IW       = 7,
  parameter int CW       = 8
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire sle_pkg::request_t request,
  output logic                done,
  output sle_pkg::result_t    result,
  input  wire logic [31:0]    head,
  input  wire logic [31:0]    second,
  output sle_pkg::cell_op_t   cell_op,
  output logic [IW-1:0]       cell_index,
  output logic [31:0]         cell_value,
  output logic [31:0]         feed
);
  import sle_pkg::*;

  localparam int W = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] step, step_next;
  logic [CW-1:0] found, found_next;
  logic [31:0]   removed, removed_next;
  func_t         op_q, op_q_next;
  logic [31:0]   value_q, value_q_next;
  logic [IW-1:0] target, target_next;
  logic          done_next;
  result_t       result_next;

  logic [W-1:0]  pos_w;
  logic [W-1:0]  count_w;
  logic          full;
  logic          bad_pos;
  logic [CW-1:0] step_c;

  assign pos_w   = W'(request.position);
  assign count_w = W'(count);
  assign full    = (count >= CAP_C);
  assign bad_pos = (pos_w == '0) || (pos_w > count_w);
  assign step_c  = CW'(step);
  assign busy    = (state == S_SCAN);

  function automatic result_t make_result(status_t st, logic [31:0] rem,
                                          logic [CW-1:0] fnd, logic [CW-1:0] cnt);
    result_t r;
    logic [W-1:0] fw;
    logic [W-1:0] cw;
    fw = W'(fnd);
    cw = W'(cnt);
    r.status         = st;
    r.removed_value  = rem;
    r.found_position = fw[7:0];
    r.count          = cw[7:0];
    return r;
  endfunction

  always_comb begin
    state_next   = state;
    count_next   = count;
    step_next    = step;
    found_next   = found;
    removed_next = removed;
    op_q_next    = op_q;
    value_q_next = value_q;
    target_next  = target;
    done_next    = 1'b0;
    result_next  = result;
    cell_op      = CELL_HOLD;
    cell_index   = '0;
    cell_value   = request.value;
    feed         = head;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_q_next    = request.func;
          value_q_next = request.value;
          target_next  = IW'(pos_w - W'(1));
          step_next    = '0;
          found_next   = '0;
          removed_next = '0;
          case (request.func)
            FUNC_APPEND: begin
              done_next = 1'b1;
              if (full) begin
                result_next = make_result(STATUS_FULL, '0, '0, count);
              end else begin
                cell_op     = CELL_APPEND;
                cell_index  = count[IW-1:0];
                count_next  = count + CW'(1);
                result_next = make_result(STATUS_OK, '0, '0, count + CW'(1));
              end
            end
            FUNC_INSERT: begin
              done_next = 1'b1;
              if (full) begin
                result_next = make_result(STATUS_FULL, '0, '0, count);
              end else if (bad_pos) begin
                result_next = make_result(STATUS_BADPOS, '0, '0, count);
              end else begin
                cell_op     = CELL_INSERT;
                cell_index  = IW'(pos_w - W'(1));
                count_next  = count + CW'(1);
                result_next = make_result(STATUS_OK, '0, '0, count + CW'(1));
              end
            end
            FUNC_DELETE: begin
              if (count == '0) begin
                done_next   = 1'b1;
                result_next = make_result(STATUS_EMPTY, '0, '0, count);
              end else if (bad_pos) begin
                done_next   = 1'b1;
                result_next = make_result(STATUS_BADPOS, '0, '0, count);
              end else begin
                state_next = S_SCAN;
              end
            end
            FUNC_FIND: begin
              if (count == '0) begin
                done_next   = 1'b1;
                result_next = make_result(STATUS_OK, '0, '0, count);
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              done_next = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        // whole ring turns once; the head cell sees each element in order
        cell_op = CELL_ROTATE;
        if (op_q == FUNC_DELETE && step >= target) begin
          feed = second;
        end
        if (op_q == FUNC_DELETE && step == target) begin
          removed_next = head;
        end
        if (op_q == FUNC_FIND && found == '0 && step_c < count && head == value_q) begin
          found_next = step_c + CW'(1);
        end
        step_next = step + IW'(1);
        if (step == LAST_IDX) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (op_q == FUNC_DELETE) begin
            count_next  = count - CW'(1);
            result_next = make_result(STATUS_OK, removed_next, '0, count - CW'(1));
          end else begin
            result_next = make_result(STATUS_OK, '0, found_next, count);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    step    <= step_next;
    found   <= found_next;
    removed <= removed_next;
    op_q    <= op_q_next;
    value_q <= value_q_next;
    target  <= target_next;
    result  <= result_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CAP_C)
    else $error("element count above capacity");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
      (state == S_SCAN && step == LAST_IDX) |=> (done && state == S_IDLE))
    else $error("scan did not finish with a result");

  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
      (done && result.removed_value != '0) |-> (result.status == STATUS_OK))
    else $error("removed value on a failed transaction");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && request.func == FUNC_APPEND && !full)
        |=> (count == $past(count) + CW'(1)))
    else $error("append did not grow the list");

endmodule
`default_nettype wire

FILE: rtl/sequential_list_engine_core.sv
// top level: ordered list of signed 32-bit elements held in a row of cells
//
// a transaction is taken when start is high and busy is low; request carries
// func, position and value. every transaction gives exactly one result on
// result, marked by done for a single cycle; the receiver cannot stall it.
// append, insert, every rejected transaction and a find on an empty list
// finish in one cycle: the result shows in the cycle after the transaction
// and the next one may be taken in that same cycle.
// an accepted delete and a find on a non-empty list turn the whole ring of
// CAPACITY cells once, reading the head cell each cycle; busy stays high while
// the ring turns, and done marks the result once the turn is over.
// insert moves the upper cells in parallel; append writes one cell.
// reset clears the element count and the state, so the list starts empty;
// cell contents are not reset and are only read once written.
// count and found_position carry the low 8 bits when CAPACITY exceeds 255.
`default_nettype none
module sequential_list_engine_core #(
  parameter int CAPACITY = 128
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire sle_pkg::request_t request,
  output logic                done,
  output sle_pkg::result_t    result
);
  import sle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  cell_op_t      cell_op;
  logic [IW-1:0] cell_index;
  logic [31:0]   cell_value;
  logic [31:0]   feed;
  logic [31:0]   cell_data [CAPACITY];

  sle_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .head       (cell_data[0]),
    .second     (cell_data[1]),
    .cell_op    (cell_op),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .feed       (feed)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] left_in;
    logic [31:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    // the ring closes through the controller at the top cell
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = feed;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    sle_cell #(
      .IDX (i),
      .IW  (IW)
    ) u_cell (
      .clk   (clk),
      .op    (cell_op),
      .index (cell_index),
      .value (cell_value),
      .left  (left_in),
      .right (right_in),
      .data  (cell_data[i])
    );
  end

endmodule
`default_nettype wire

FILE: test/sle_list_monitor.sv
// monitor for the sequential list engine: predicts each result and compares it
`default_nettype none
module sle_list_monitor #(
  parameter int CAPACITY = 128
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire                busy,
  input  wire sle_pkg::request_t request,
  input  wire                done,
  input  wire sle_pkg::result_t  result,
  output int                 fail_count,
  output int                 pending,
  output int                 list_len
);
  import sle_pkg::*;

  // shadow copy of the list contents and length
  logic signed [31:0] cells [CAPACITY];
  int                 len = 0;
  int                 fails = 0;
  result_t            expected_q [$];

  function automatic result_t apply_request(request_t rq);
    result_t r;
    int      i;
    int      p;
    r = '0;
    r.status = STATUS_OK;
    p = rq.position;
    case (rq.func)
      FUNC_APPEND: begin
        if (len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else begin
          cells[len] = rq.value;
          len++;
        end
      end
      FUNC_INSERT: begin
        // full is tested before the position
        if (len >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (p < 1 || p > len) begin
          r.status = STATUS_BADPOS;
        end else begin
          for (i = len; i > p - 1; i--) cells[i] = cells[i - 1];
          cells[p - 1] = rq.value;
          len++;
        end
      end
      FUNC_DELETE: begin
        // empty is tested before the position
        if (len == 0) begin
          r.status = STATUS_EMPTY;
        end else if (p < 1 || p > len) begin
          r.status = STATUS_BADPOS;
        end else begin
          r.removed_value = cells[p - 1];
          for (i = p - 1; i + 1 < len; i++) cells[i] = cells[i + 1];
          len--;
        end
      end
      default: begin
        for (i = 0; i < len; i++) begin
          if (cells[i] == rq.value) begin
            r.found_position = 8'(i + 1);
            break;
          end
        end
      end
    endcase
    r.count = 8'(len);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      len = 0;
      expected_q.delete();
    end else begin
      // retire the older transaction before taking a new one
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (result.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, result.status);
            fails++;
          end
          if (result.removed_value !== want.removed_value) begin
            $error("removed_value expected %0d got %0d", want.removed_value,
                   result.removed_value);
            fails++;
          end
          if (result.found_position !== want.found_position) begin
            $error("found_position expected %0d got %0d", want.found_position,
                   result.found_position);
            fails++;
          end
          if (result.count !== want.count) begin
            $error("count expected %0d got %0d", want.count, result.count);
            fails++;
          end
        end
      end
      if (start && !busy) expected_q.push_back(apply_request(request));
    end
    fail_count <= fails;
    pending    <= expected_q.size();
    list_len   <= len;
  end

endmodule
`default_nettype wire

FILE: test/sequential_list_engine_core_tb.sv
// testbench top for the sequential list engine: stimulus, timeout and verdict
`default_nettype none
module sequential_list_engine_core_tb;
  import sle_pkg::*;

  localparam int CAPACITY     = 128;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  wire      busy;
  wire      done;
  result_t  result;
  int       fail_count;
  int       pending;
  int       list_len;
  int       cycles = 0;

  // small pool of values so that finds hit and duplicates occur
  logic signed [31:0] pool [16];

  sequential_list_engine_core #(.CAPACITY(CAPACITY)) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  sle_list_monitor #(.CAPACITY(CAPACITY)) list_monitor (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending),
    .list_len   (list_len)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** sequential_list_engine_core: FAILED **");
      $finish;
    end
  end

  function automatic request_t mk_request(func_t f, logic [7:0] p, logic signed [31:0] v);
    request_t rq;
    rq.func     = f;
    rq.position = p;
    rq.value    = v;
    return rq;
  endfunction

  function automatic logic signed [31:0] draw_value();
    if ($urandom_range(0, 3) != 0) return pool[$urandom_range(0, 15)];
    return $signed($urandom);
  endfunction

  // growing phases favour append and insert, shrinking phases favour delete
  function automatic request_t draw_request(int len, bit rising);
    request_t rq;
    int       r;
    int       t_app;
    int       t_ins;
    r     = $urandom_range(0, 99);
    t_app = rising ? 35 : 5;
    t_ins = rising ? 65 : 15;
    rq = mk_request(FUNC_FIND, 8'($urandom_range(0, 128)), draw_value());
    if (r < t_app) begin
      rq.func = FUNC_APPEND;
    end else if (r < t_ins) begin
      rq.func = FUNC_INSERT;
      if (len > 0) rq.position = 8'($urandom_range(1, len));
    end else if (r < 75) begin
      rq.func = FUNC_DELETE;
      if (len > 0) rq.position = 8'($urandom_range(1, len));
    end else if (r < 90) begin
      rq.func = FUNC_FIND;
    end else begin
      rq.func = func_t'($urandom_range(0, 3));
      case ($urandom_range(0, 2))
        0: rq.position = 8'd0;
        1: rq.position = 8'((len < CAPACITY) ? len + 1 : CAPACITY);
        default: ;
      endcase
    end
    return rq;
  endfunction

  // holds start high until the transaction is taken; leaves start high
  task automatic send(input request_t rq, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    request_t rq;
    int       n;
    bit       rising;
    int       special;
    bit       burst;
    rising  = 1'b1;
    special = 0;
    burst   = 1'b0;
    pool[0] = 32'sh7fffffff;
    pool[1] = 32'sh80000000;
    pool[2] = 32'sd0;
    pool[3] = -32'sd1;
    for (n = 4; n < 16; n++) pool[n] = $signed($urandom);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list corner cases
    send(mk_request(FUNC_FIND,   8'd5,   32'sd5), $urandom_range(0, 3));
    send(mk_request(FUNC_DELETE, 8'd1,   32'sd0), $urandom_range(0, 3));
    send(mk_request(FUNC_DELETE, 8'd0,   32'sd0), $urandom_range(0, 3));
    send(mk_request(FUNC_INSERT, 8'd1,   32'sd9), $urandom_range(0, 3));
    send(mk_request(FUNC_INSERT, 8'd0,   32'sd9), $urandom_range(0, 3));
    // extreme values
    send(mk_request(FUNC_APPEND, 8'd128, 32'sh7fffffff), $urandom_range(0, 3));
    send(mk_request(FUNC_APPEND, 8'd0,   32'sh80000000), $urandom_range(0, 3));
    send(mk_request(FUNC_APPEND, 8'd255, 32'sd0), $urandom_range(0, 3));
    send(mk_request(FUNC_APPEND, 8'd1,   -32'sd1), $urandom_range(0, 3));
    send(mk_request(FUNC_INSERT, 8'd1,   32'sd12345), $urandom_range(0, 3));
    send(mk_request(FUNC_INSERT, 8'd5,   32'sh7fffffff), $urandom_range(0, 3));
    // tail insert is rejected, append covers it
    send(mk_request(FUNC_INSERT, 8'd7,   32'sd1), $urandom_range(0, 3));
    send(mk_request(FUNC_INSERT, 8'd0,   32'sd1), $urandom_range(0, 3));
    send(mk_request(FUNC_FIND,   8'd0,   32'sh7fffffff), $urandom_range(0, 3));
    send(mk_request(FUNC_FIND,   8'd128, 32'sh80000000), $urandom_range(0, 3));
    send(mk_request(FUNC_FIND,   8'd3,   32'sh5a5a5a5a), $urandom_range(0, 3));
    send(mk_request(FUNC_DELETE, 8'd0,   32'sd0), $urandom_range(0, 3));
    send(mk_request(FUNC_DELETE, 8'd7,   32'sd0), $urandom_range(0, 3));
    send(mk_request(FUNC_DELETE, 8'd128, 32'sd0), $urandom_range(0, 3));
    send(mk_request(FUNC_DELETE, 8'd1,   32'sd0), $urandom_range(0, 3));
    send(mk_request(FUNC_DELETE, 8'd5,   32'sd0), $urandom_range(0, 3));
    send(mk_request(FUNC_FIND,   8'd0,   -32'sd1), $urandom_range(0, 3));
    send(mk_request(FUNC_INSERT, 8'd4,   32'sh80000000), $urandom_range(0, 3));
    send(mk_request(FUNC_FIND,   8'd0,   32'sh80000000), $urandom_range(0, 3));

    // let the list drain its outstanding work before the random part
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) pool[$urandom_range(4, 15)] = $signed($urandom);
      if (rising && list_len == CAPACITY) begin
        rising  = 1'b0;
        special = 3;
      end else if (!rising && list_len == 0) begin
        rising  = 1'b1;
        special = 3;
      end
      if (special > 0) begin
        // probe the full or empty list before moving away from it
        if (!rising) begin
          case (special)
            3: rq = mk_request(FUNC_APPEND, 8'($urandom_range(0, 128)), draw_value());
            2: rq = mk_request(FUNC_INSERT, 8'($urandom_range(0, 128)), draw_value());
            default: rq = mk_request(FUNC_DELETE, 8'(CAPACITY), draw_value());
          endcase
        end else begin
          case (special)
            3: rq = mk_request(FUNC_DELETE, 8'($urandom_range(0, 128)), draw_value());
            2: rq = mk_request(FUNC_FIND, 8'($urandom_range(0, 128)), draw_value());
            default: rq = mk_request(FUNC_INSERT, 8'd1, draw_value());
          endcase
        end
        special--;
      end else begin
        rq = draw_request(list_len, rising);
      end
      send(rq, burst ? 0 : $urandom_range(0, 3));
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CAPACITY + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("** sequential_list_engine_core: PASSED **");
    end else begin
      $display("** sequential_list_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
